### hw/rtl/sjsg_pkg.sv
// ----------------------------------------------------------------------------
// sjsg_pkg: shared types and constants of the sine joint setpoint generator
// Register indexes, fixed-point constants, the controller state type and the
// command, status and record structs passed between the modules.
// ----------------------------------------------------------------------------
package sjsg_pkg;

	// Configuration register indexes.
	localparam logic [2:0] CFG_ACTIVE_MOTOR = 3'd0;
	localparam logic [2:0] CFG_START_DELAY  = 3'd1;
	localparam logic [2:0] CFG_RUN_TICKS    = 3'd2;
	localparam logic [2:0] CFG_CENTER       = 3'd3;
	localparam logic [2:0] CFG_AMPLITUDE    = 3'd4;
	localparam logic [2:0] CFG_PHASE_STEP   = 3'd5;
	localparam logic [2:0] CFG_ACTIVE_KP    = 3'd6;
	localparam logic [2:0] CFG_ACTIVE_KD    = 3'd7;

	// Configuration reset values.
	localparam logic [3:0]         RST_ACTIVE_MOTOR = 4'd0;
	localparam logic [31:0]        RST_START_DELAY  = 32'd100;
	localparam logic [31:0]        RST_RUN_TICKS    = 32'd0;
	localparam logic signed [15:0] RST_CENTER       = 16'sd0;
	localparam logic [14:0]        RST_AMPLITUDE    = 15'd614;
	localparam logic [31:0]        RST_PHASE_STEP   = 32'd10737418;
	localparam logic [15:0]        RST_ACTIVE_KP    = 16'd1536;
	localparam logic [15:0]        RST_ACTIVE_KD    = 16'd77;

	// Fixed-point constants: pi/2 in Q30 and 2*pi in Q28.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TWO_PI_Q28  = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;

	// Saturation limits of the command fields.
	localparam logic signed [31:0] POS_MAX = 32'sd32767;
	localparam logic signed [31:0] POS_MIN = -32'sd32768;
	localparam logic signed [63:0] VEL_MAX = 64'sd8388607;
	localparam logic signed [63:0] VEL_MIN = -64'sd8388608;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COUNT,
		ST_WINDOW,
		ST_PHASE,
		ST_SIN_RD,
		ST_SIN,
		ST_COS,
		ST_MUL_AC,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_VEL,
		ST_EMIT
	} sjsg_state_t;

	// Step commands from the controller to the datapath.
	typedef struct packed {
		logic count;
		logic window;
		logic phase;
		logic cap_sin;
		logic cap_cos;
		logic mul_ac;
		logic mul_lo;
		logic mul_hi;
		logic vel;
		logic idx_inc;
	} sjsg_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic last;
	} sjsg_stat_t;

	// One motor command record.
	typedef struct packed {
		logic [3:0]         motor_number;
		logic signed [15:0] position_command;
		logic signed [23:0] velocity_command;
		logic signed [15:0] torque_command;
		logic [15:0]        stiffness_gain;
		logic [15:0]        damping_gain;
		logic               last_record;
	} sjsg_rec_t;

endpackage

### hw/rtl/sjsg_tick_if.sv
// ----------------------------------------------------------------------------
// sjsg_tick_if: command period tick channel
// Valid/ready channel that carries one period tick per beat.
// ----------------------------------------------------------------------------
interface sjsg_tick_if;
	logic valid;
	logic ready;
	logic period_tick;

	modport source (output valid, output period_tick, input ready);
	modport sink (input valid, input period_tick, output ready);
endinterface

### hw/rtl/sjsg_cmd_if.sv
// ----------------------------------------------------------------------------
// sjsg_cmd_if: motor command record channel
// Valid/ready channel that carries one motor command record per beat.
// ----------------------------------------------------------------------------
interface sjsg_cmd_if;
	logic               valid;
	logic               ready;
	logic [3:0]         motor_number;
	logic signed [15:0] position_command;
	logic signed [23:0] velocity_command;
	logic signed [15:0] torque_command;
	logic [15:0]        stiffness_gain;
	logic [15:0]        damping_gain;
	logic               last_record;

	modport source (
		output valid, output motor_number, output position_command,
		output velocity_command, output torque_command, output stiffness_gain,
		output damping_gain, output last_record, input ready
	);
	modport sink (
		input valid, input motor_number, input position_command,
		input velocity_command, input torque_command, input stiffness_gain,
		input damping_gain, input last_record, output ready
	);
endinterface

### hw/rtl/sjsg_cfg_if.sv
// ----------------------------------------------------------------------------
// sjsg_cfg_if: configuration write channel
// Valid/ready channel that carries one register index and its data per beat.
// ----------------------------------------------------------------------------
interface sjsg_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/sjsg_sine_rom.sv
// ----------------------------------------------------------------------------
// sjsg_sine_rom: quarter-wave sine table
// Holds sin(pi/2 * k / SINE_ENTRIES) in Q14 for k = 0..SINE_ENTRIES, filled
// at elaboration from a Taylor series, with a registered read port.
// ----------------------------------------------------------------------------
module sjsg_sine_rom #(
	parameter int SINE_ENTRIES = 1024,
	localparam int AW = $clog2(SINE_ENTRIES + 1)
) (
	input  logic          clk,
	input  logic [AW-1:0] addr,
	output logic [14:0]   data_q
);
	import sjsg_pkg::*;

	typedef logic [14:0] rom_t [SINE_ENTRIES + 1];

	localparam logic [63:0] TAYLOR_DIV [6] = '{
		64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
	};

	// Horner evaluation on unsigned Q30 values, rounded half up to Q14.
	function automatic logic [14:0] quarter_sample(input logic [63:0] k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		x  = (HALF_PI_Q30 * k) / 64'(SINE_ENTRIES);
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		for (int i = 0; i < 6; i++) begin
			t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_DIV[i];
		end
		return 15'((((x * t) >> 30) + 64'd32768) >> 16);
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int j = 0; j <= SINE_ENTRIES; j++) begin
			r[j] = quarter_sample(64'(j));
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// Registered table read.
	always_ff @(posedge clk) begin
		data_q <= SINE_ROM[addr];
	end

endmodule

### hw/rtl/sjsg_ctrl.sv
// ----------------------------------------------------------------------------
// sjsg_ctrl: sequencing controller
// Accepts ticks, steps the datapath through the trajectory computation and
// then hands out one record per motor on the output channel.
// ----------------------------------------------------------------------------
module sjsg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick_valid,
	input  logic                 tick_period,
	output logic                 tick_ready,
	output logic                 rec_valid,
	input  logic                 rec_ready,
	output sjsg_pkg::sjsg_cmd_t  cmd,
	input  sjsg_pkg::sjsg_stat_t stat
);
	import sjsg_pkg::*;

	sjsg_state_t state_q;
	sjsg_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		tick_ready = 1'b0;
		rec_valid  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				tick_ready = 1'b1;
				if (tick_valid && tick_period) begin
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				state_d   = ST_WINDOW;
			end
			ST_WINDOW: begin
				cmd.window = 1'b1;
				state_d    = ST_PHASE;
			end
			ST_PHASE: begin
				cmd.phase = 1'b1;
				state_d   = ST_SIN_RD;
			end
			ST_SIN_RD: begin
				state_d = ST_SIN;
			end
			ST_SIN: begin
				cmd.cap_sin = 1'b1;
				state_d     = ST_COS;
			end
			ST_COS: begin
				cmd.cap_cos = 1'b1;
				state_d     = ST_MUL_AC;
			end
			ST_MUL_AC: begin
				cmd.mul_ac = 1'b1;
				state_d    = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_VEL;
			end
			ST_VEL: begin
				cmd.vel = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				rec_valid = 1'b1;
				if (rec_ready) begin
					if (stat.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/sjsg_dp.sv
// ----------------------------------------------------------------------------
// sjsg_dp: trajectory datapath
// Configuration registers, tick counter, phase and rate arithmetic, sine and
// cosine sampling, position and velocity targets and the record builder.
// ----------------------------------------------------------------------------
module sjsg_dp #(
	parameter int NUM_MOTORS = 12,
	parameter int SINE_ENTRIES = 1024,
	parameter int TICK_RATE_HZ = 100,
	parameter int HOLD_DAMPING = 205,
	parameter int FEED_TORQUE = 0,
	localparam int AW = $clog2(SINE_ENTRIES + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  sjsg_pkg::sjsg_cmd_t  cmd,
	output sjsg_pkg::sjsg_stat_t stat,
	output logic [AW-1:0]        rom_addr,
	input  logic [14:0]          rom_data,
	output sjsg_pkg::sjsg_rec_t  rec
);
	import sjsg_pkg::*;

	localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_MOTORS - 1);

	// Configuration registers.
	logic [3:0]         active_q;
	logic [31:0]        start_q;
	logic [31:0]        run_q;
	logic signed [15:0] center_q;
	logic [14:0]        amp_q;
	logic [31:0]        step_q;
	logic [15:0]        kp_q;
	logic [15:0]        kd_q;

	// Sequencing state.
	logic [31:0]      tick_q;
	logic [IDX_W-1:0] idx_q;

	// Working registers.
	logic               en_q;
	logic [31:0]        diff_q;
	logic [34:0]        wtick_q;
	logic [31:0]        phase_q;
	logic [31:0]        omega_q;
	logic signed [15:0] sin_q;
	logic signed [15:0] cos_q;
	logic signed [31:0] ps_q;
	logic signed [31:0] ac_q;
	logic signed [48:0] plo_q;
	logic signed [48:0] phi_q;
	logic signed [15:0] pos_q;
	logic signed [23:0] vel_q;

	logic [32:0]        win_end;
	logic               in_window;
	logic [63:0]        wtick_prod;
	logic [49:0]        omega_prod;
	logic [31:0]        phase_next;
	logic [31:0]        cos_phase;
	logic [31:0]        rd_phase;
	logic [30+AW-1:0]   scaled;
	logic [AW-1:0]      qidx;
	logic signed [15:0] mag;
	logic signed [31:0] amp_s;
	logic signed [31:0] pos_sum;
	logic signed [63:0] vel_sum;
	logic signed [63:0] vel_rnd;
	logic [IDX_W-1:0]   act_sel;
	logic               hit;

	// Configuration writes and tick/record counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= RST_ACTIVE_MOTOR;
			start_q  <= RST_START_DELAY;
			run_q    <= RST_RUN_TICKS;
			center_q <= RST_CENTER;
			amp_q    <= RST_AMPLITUDE;
			step_q   <= RST_PHASE_STEP;
			kp_q     <= RST_ACTIVE_KP;
			kd_q     <= RST_ACTIVE_KD;
			tick_q   <= '0;
			idx_q    <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ACTIVE_MOTOR: active_q <= cfg_data[3:0];
					CFG_START_DELAY:  start_q  <= cfg_data;
					CFG_RUN_TICKS:    run_q    <= cfg_data;
					CFG_CENTER:       center_q <= signed'(cfg_data[15:0]);
					CFG_AMPLITUDE:    amp_q    <= cfg_data[14:0];
					CFG_PHASE_STEP:   step_q   <= cfg_data;
					CFG_ACTIVE_KP:    kp_q     <= cfg_data[15:0];
					CFG_ACTIVE_KD:    kd_q     <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.count) begin
				if (tick_q != '1) begin
					tick_q <= tick_q + 32'd1;
				end
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// Motion window, phase and angular rate arithmetic.
	always_comb begin
		win_end    = {1'b0, start_q} + {1'b0, run_q};
		in_window  = (tick_q >= start_q) && ((run_q == '0) || ({1'b0, tick_q} <= win_end));
		wtick_prod = 64'(step_q) * TWO_PI_Q28 + 64'd134217728;
		omega_prod = 50'(wtick_q) * 50'(TICK_RATE_HZ) + 50'd32768;
		phase_next = diff_q * step_q;
	end

	// Table address: quarter index, mirrored in odd quadrants.
	always_comb begin
		cos_phase = phase_q + 32'h4000_0000;
		rd_phase  = cmd.cap_sin ? cos_phase : phase_q;
		scaled    = (30 + AW)'(rd_phase[29:0]) * (30 + AW)'(SINE_ENTRIES);
		qidx      = scaled[30+AW-1:30];
		rom_addr  = rd_phase[30] ? (AW'(SINE_ENTRIES) - qidx) : qidx;
		mag       = signed'({1'b0, rom_data});
	end

	// Position and velocity arithmetic.
	always_comb begin
		amp_s   = signed'(32'(amp_q));
		pos_sum = 32'(center_q) + ((ps_q + 32'sd8192) >>> 14);
		vel_sum = (64'(phi_q) <<< 16) + 64'(plo_q) + 64'sd536870912;
		vel_rnd = vel_sum >>> 30;
	end

	// Computation registers, loaded one step at a time.
	always_ff @(posedge clk) begin
		if (cmd.window) begin
			en_q    <= in_window;
			diff_q  <= tick_q - start_q;
			wtick_q <= wtick_prod[62:28];
		end
		if (cmd.phase) begin
			phase_q <= en_q ? phase_next : '0;
			omega_q <= omega_prod[47:16];
		end
		if (cmd.cap_sin) begin
			sin_q <= phase_q[31] ? -mag : mag;
		end
		if (cmd.cap_cos) begin
			cos_q <= cos_phase[31] ? -mag : mag;
			ps_q  <= amp_s * 32'(sin_q);
		end
		if (cmd.mul_ac) begin
			ac_q <= amp_s * 32'(cos_q);
			if (!en_q) begin
				pos_q <= center_q;
			end else if (pos_sum > POS_MAX) begin
				pos_q <= 16'sh7FFF;
			end else if (pos_sum < POS_MIN) begin
				pos_q <= -16'sh8000;
			end else begin
				pos_q <= 16'(pos_sum);
			end
		end
		if (cmd.mul_lo) begin
			plo_q <= 49'(ac_q) * signed'({33'b0, omega_q[15:0]});
		end
		if (cmd.mul_hi) begin
			phi_q <= 49'(ac_q) * signed'({33'b0, omega_q[31:16]});
		end
		if (cmd.vel) begin
			if (!en_q) begin
				vel_q <= '0;
			end else if (vel_rnd > VEL_MAX) begin
				vel_q <= 24'sh7FFFFF;
			end else if (vel_rnd < VEL_MIN) begin
				vel_q <= -24'sh800000;
			end else begin
				vel_q <= 24'(vel_rnd);
			end
		end
	end

	// Record for the motor at the current index.
	always_comb begin
		act_sel = (32'(active_q) > NUM_MOTORS - 1) ? IDX_LAST : IDX_W'(active_q);
		hit     = (idx_q == act_sel);
		stat.last = (idx_q == IDX_LAST);
		rec.motor_number     = 4'(idx_q);
		rec.position_command = hit ? pos_q : center_q;
		rec.velocity_command = hit ? vel_q : '0;
		rec.torque_command   = hit ? 16'(FEED_TORQUE) : '0;
		rec.stiffness_gain   = hit ? kp_q : '0;
		rec.damping_gain     = hit ? kd_q : 16'(HOLD_DAMPING);
		rec.last_record      = stat.last;
	end

endmodule

### hw/rtl/sine_joint_setpoint_generator.sv
// ----------------------------------------------------------------------------
// sine_joint_setpoint_generator: sine trajectory setpoints for a motor group
// Turns command period ticks into one command record per motor, driving the
// selected motor along a sine around its center position.
// ----------------------------------------------------------------------------
// Usage:
//   tick carries one period tick per beat. A beat with period_tick low is
//   taken and produces nothing. A tick produces NUM_MOTORS records on
//   setpoint, motor 0 first, last_record set on the final one.
//   cfg writes one register per beat (index 0..7) and is always ready. Write
//   it only while the block is idle, between ticks.
// Timing:
//   The first record of a tick is valid once the controller has stepped
//   through its count, window, phase, table-read, sine, cosine, multiply
//   and velocity states; the records then follow one per cycle while
//   setpoint is ready. tick is ready only between ticks.
// Reset and stalls:
//   Reset clears the tick counter and loads the default registers. A stalled
//   receiver holds the current record steady until it is taken.
// ----------------------------------------------------------------------------
module sine_joint_setpoint_generator #(
	parameter int NUM_MOTORS = 12,
	parameter int SINE_ENTRIES = 1024,
	parameter int TICK_RATE_HZ = 100,
	parameter int HOLD_DAMPING = 205,
	parameter int FEED_TORQUE = 0
) (
	input logic        clk,
	input logic        arst_n,
	sjsg_tick_if.sink  tick,
	sjsg_cmd_if.source setpoint,
	sjsg_cfg_if.sink   cfg
);
	import sjsg_pkg::*;

	localparam int AW = $clog2(SINE_ENTRIES + 1);

	sjsg_cmd_t     cmd;
	sjsg_stat_t    stat;
	sjsg_rec_t     rec;
	logic [AW-1:0] rom_addr;
	logic [14:0]   rom_data;

	// Configuration port never stalls.
	assign cfg.ready = 1'b1;

	sjsg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_valid  (tick.valid),
		.tick_period (tick.period_tick),
		.tick_ready  (tick.ready),
		.rec_valid   (setpoint.valid),
		.rec_ready   (setpoint.ready),
		.cmd         (cmd),
		.stat        (stat)
	);

	sjsg_dp #(
		.NUM_MOTORS   (NUM_MOTORS),
		.SINE_ENTRIES (SINE_ENTRIES),
		.TICK_RATE_HZ (TICK_RATE_HZ),
		.HOLD_DAMPING (HOLD_DAMPING),
		.FEED_TORQUE  (FEED_TORQUE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.stat      (stat),
		.rom_addr  (rom_addr),
		.rom_data  (rom_data),
		.rec       (rec)
	);

	sjsg_sine_rom #(
		.SINE_ENTRIES (SINE_ENTRIES)
	) u_rom (
		.clk    (clk),
		.addr   (rom_addr),
		.data_q (rom_data)
	);

	// Record fields onto the output channel.
	assign setpoint.motor_number     = rec.motor_number;
	assign setpoint.position_command = rec.position_command;
	assign setpoint.velocity_command = rec.velocity_command;
	assign setpoint.torque_command   = rec.torque_command;
	assign setpoint.stiffness_gain   = rec.stiffness_gain;
	assign setpoint.damping_gain     = rec.damping_gain;
	assign setpoint.last_record      = rec.last_record;

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sine joint setpoint generator
// Sends period ticks and register writes over valid/ready channels, with
// random idling on both sides. Every tick is predicted in fixed point as one
// record per motor, and each record beat is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench;
	import sjsg_pkg::*;

	localparam int NUM_MOTORS    = 12;
	localparam int SINE_ENTRIES  = 1024;
	localparam int TICK_RATE_HZ  = 100;
	localparam int HOLD_DAMPING  = 205;
	localparam int FEED_TORQUE   = 0;
	localparam int IDLE_PCT      = 38;
	localparam int SETTLE_CYCLES = 40;
	localparam int QUIET_LIMIT   = 3000;
	localparam int TICK_TARGET   = 340;
	localparam int REPORT_LIMIT  = 10;

	// Divisors of the Horner steps of the sine series, innermost first.
	localparam longint unsigned TAYLOR_DIV [6] = '{156, 110, 72, 42, 20, 6};

	logic clk = 1'b0;
	logic arst_n;
	logic calm_mode = 1'b0;

	sjsg_tick_if tick_bus ();
	sjsg_cmd_if  cmd_bus ();
	sjsg_cfg_if  cfg_bus ();

	sine_joint_setpoint_generator #(
		.NUM_MOTORS  (NUM_MOTORS),
		.SINE_ENTRIES(SINE_ENTRIES),
		.TICK_RATE_HZ(TICK_RATE_HZ),
		.HOLD_DAMPING(HOLD_DAMPING),
		.FEED_TORQUE (FEED_TORQUE)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_bus),
		.setpoint(cmd_bus),
		.cfg     (cfg_bus)
	);

	// Register shadows and tick counter of the prediction.
	logic [3:0]         sh_motor;
	logic [31:0]        sh_start;
	logic [31:0]        sh_run;
	logic signed [15:0] sh_center;
	logic [14:0]        sh_amp;
	logic [31:0]        sh_step;
	logic [15:0]        sh_kp;
	logic [15:0]        sh_kd;
	logic [31:0]        tick_count_model;

	sjsg_rec_t expected_records [$];

	int mismatches      = 0;
	int records_checked = 0;
	int ticks_sent      = 0;
	int empty_beats     = 0;
	int writes_done     = 0;
	int quiet_cycles    = 0;

	always #5 clk = ~clk;

	// Sine of quarter index k, Horner series on Q30, rounded to Q14.
	function automatic int quarter_wave(input int k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		x = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_ENTRIES);
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		for (int i = 0; i < 6; i++)
			t = Q30_ONE - (((x2 * t) >> 30) / TAYLOR_DIV[i]);
		return int'((((x * t) >> 30) + 64'd32768) >> 16);
	endfunction

	// Full-turn sine from the quarter table: odd quadrants mirror, upper half negates.
	function automatic int wave_sample(input logic [31:0] phase);
		int k;
		int v;
		k = int'(phase[29:20]);
		if (phase[30])
			k = SINE_ENTRIES - k;
		v = quarter_wave(k);
		return phase[31] ? -v : v;
	endfunction

	// Division by 2^sh rounded half toward plus infinity.
	function automatic longint round_half_up(input longint v, input int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	// Advances the tick counter and queues the records of one tick.
	function automatic void predict_tick_records();
		logic [31:0]     phase;
		logic [32:0]     window_end;
		logic            moving;
		longint unsigned w_tick;
		longint unsigned omega;
		longint          pos;
		longint          vel;
		int              sin_v;
		int              cos_v;
		int              active;
		sjsg_rec_t       rec;
		if (tick_count_model != 32'hFFFF_FFFF)
			tick_count_model++;
		window_end = {1'b0, sh_start} + {1'b0, sh_run};
		moving = (tick_count_model >= sh_start) &&
			(sh_run == 32'd0 || {1'b0, tick_count_model} <= window_end);
		pos = sh_center;
		vel = 0;
		if (moving) begin
			phase = (tick_count_model - sh_start) * sh_step;
			sin_v = wave_sample(phase);
			cos_v = wave_sample(phase + 32'h4000_0000);
			w_tick = ({32'd0, sh_step} * TWO_PI_Q28 + 64'd134217728) >> 28;
			omega = (w_tick * 64'(TICK_RATE_HZ) + 64'd32768) >> 16;
			pos = pos + round_half_up(longint'(sh_amp) * longint'(sin_v), 14);
			if (pos > 32767)
				pos = 32767;
			else if (pos < -32768)
				pos = -32768;
			vel = round_half_up(longint'(sh_amp) * longint'(cos_v) * longint'(omega), 30);
			if (vel > 8388607)
				vel = 8388607;
			else if (vel < -8388608)
				vel = -8388608;
		end
		active = (sh_motor > NUM_MOTORS - 1) ? NUM_MOTORS - 1 : int'(sh_motor);
		for (int m = 0; m < NUM_MOTORS; m++) begin
			rec.motor_number = 4'(m);
			if (m == active) begin
				rec.position_command = pos[15:0];
				rec.velocity_command = vel[23:0];
				rec.torque_command   = 16'(FEED_TORQUE);
				rec.stiffness_gain   = sh_kp;
				rec.damping_gain     = sh_kd;
			end else begin
				rec.position_command = sh_center;
				rec.velocity_command = '0;
				rec.torque_command   = '0;
				rec.stiffness_gain   = '0;
				rec.damping_gain     = 16'(HOLD_DAMPING);
			end
			rec.last_record = (m == NUM_MOTORS - 1);
			expected_records.push_back(rec);
		end
	endfunction

	// Sends one beat on the tick channel after a random idle gap.
	task automatic send_beat(input logic tick);
		int gap;
		gap = 0;
		if (!calm_mode)
			while ($urandom_range(99) < IDLE_PCT)
				gap++;
		if (gap > 0) begin
			tick_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_bus.valid <= 1'b1;
		tick_bus.period_tick <= tick;
		@(posedge clk);
		while (!tick_bus.ready)
			@(posedge clk);
		if (tick) begin
			predict_tick_records();
			ticks_sent++;
		end else begin
			empty_beats++;
		end
	endtask

	// Holds off ticks until every record has come, then lets the block settle.
	task automatic wait_for_drain();
		tick_bus.valid <= 1'b0;
		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register and mirrors it in the prediction.
	task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= index;
		cfg_bus.data <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		cfg_bus.valid <= 1'b0;
		writes_done++;
		case (index)
			CFG_ACTIVE_MOTOR: sh_motor = value[3:0];
			CFG_START_DELAY:  sh_start = value;
			CFG_RUN_TICKS:    sh_run = value;
			CFG_CENTER:       sh_center = value[15:0];
			CFG_AMPLITUDE:    sh_amp = value[14:0];
			CFG_PHASE_STEP:   sh_step = value;
			CFG_ACTIVE_KP:    sh_kp = value[15:0];
			CFG_ACTIVE_KD:    sh_kd = value[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(input logic [3:0] motor, input logic [31:0] start,
		input logic [31:0] run, input logic signed [15:0] center, input logic [14:0] amp,
		input logic [31:0] step, input logic [15:0] kp, input logic [15:0] kd);
		write_reg(CFG_ACTIVE_MOTOR, {28'd0, motor});
		write_reg(CFG_START_DELAY, start);
		write_reg(CFG_RUN_TICKS, run);
		write_reg(CFG_CENTER, {16'd0, center});
		write_reg(CFG_AMPLITUDE, {17'd0, amp});
		write_reg(CFG_PHASE_STEP, step);
		write_reg(CFG_ACTIVE_KP, {16'd0, kp});
		write_reg(CFG_ACTIVE_KD, {16'd0, kd});
	endtask

	// Reset registers: ticks before the delay, an empty beat, then default motion.
	task automatic test_reset_state();
		send_beat(1'b1);
		send_beat(1'b0);
		send_beat(1'b1);
		wait_for_drain();
		write_reg(CFG_START_DELAY, tick_count_model + 32'd1);
		repeat (2) send_beat(1'b1);
		wait_for_drain();
	endtask

	// Saturation of position and velocity, motor index clamp, gain extremes.
	task automatic test_motion_limits();
		write_all(4'd15, 32'd0, 32'd0, 16'sh7FFF, 15'h7FFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
		repeat (3) send_beat(1'b1);
		wait_for_drain();
		// A quarter turn per tick lands on every quadrant boundary.
		write_all(4'd11, 32'd0, 32'd0, 16'sh8000, 15'h7FFF, 32'h4000_0000, 16'h0000, 16'hFFFF);
		repeat (4) send_beat(1'b1);
		wait_for_drain();
		write_all(4'd0, 32'd0, 32'd0, 16'sd0, 15'd0, 32'd0, 16'd0, 16'd0);
		send_beat(1'b1);
		wait_for_drain();
	endtask

	// A short window opens after the delay and closes after run_ticks.
	task automatic test_motion_window();
		write_all(4'd5, tick_count_model + 32'd2, 32'd3, 16'sd1000, 15'd4000, 32'h1000_0000,
			16'd300, 16'd40);
		repeat (7) send_beat(1'b1);
		wait_for_drain();
	endtask

	// A window end past the counter range never closes; a maximal delay never opens.
	task automatic test_window_overflow();
		write_reg(CFG_START_DELAY, tick_count_model + 32'd1);
		write_reg(CFG_RUN_TICKS, 32'hFFFF_FFFF);
		repeat (3) send_beat(1'b1);
		wait_for_drain();
		write_reg(CFG_START_DELAY, 32'hFFFF_FFFF);
		write_reg(CFG_RUN_TICKS, 32'd0);
		repeat (2) send_beat(1'b1);
		wait_for_drain();
	endtask

	// Phases of random settings, each followed by a burst of ticks.
	task automatic test_random_traffic();
		int          phase_no;
		int          n;
		int          pick;
		logic [31:0] start;
		logic [31:0] run;
		logic [31:0] step;
		logic [14:0] amp;
		phase_no = 0;
		while (ticks_sent < TICK_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 10)
				start = 32'd0;
			else if (pick < 18)
				start = 32'hFFFF_FFFF;
			else if (pick < 26)
				start = tick_count_model - $urandom_range(0, 20);
			else
				start = tick_count_model + $urandom_range(0, 8);
			pick = $urandom_range(99);
			if (pick < 40)
				run = 32'd0;
			else if (pick < 85)
				run = $urandom_range(1, 25);
			else if (pick < 93)
				run = 32'hFFFF_FFFF;
			else
				run = $urandom;
			amp = ($urandom_range(1) != 0) ? 15'($urandom) : 15'($urandom_range(0, 2000));
			step = ($urandom_range(3) != 0) ? $urandom : $urandom_range(0, 32'h0100_0000);
			write_all(4'($urandom_range(0, 15)), start, run, 16'($urandom), amp, step,
				16'($urandom), 16'($urandom));
			// One phase runs with neither side idling.
			calm_mode <= (phase_no == 3);
			n = (phase_no == 3) ? 40 : $urandom_range(12, 30);
			repeat (n) begin
				if ($urandom_range(99) < 10)
					send_beat(1'b0);
				else
					send_beat(1'b1);
				if ($urandom_range(99) < 3)
					wait_for_drain();
			end
			wait_for_drain();
			calm_mode <= 1'b0;
			phase_no++;
		end
	endtask

	// Receiver side: random stalls on the record channel.
	initial begin
		cmd_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			cmd_bus.ready <= calm_mode || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Each record beat is compared with the oldest prediction.
	always @(posedge clk) begin
		sjsg_rec_t seen;
		sjsg_rec_t want;
		logic      bad;
		if (arst_n && cmd_bus.valid && cmd_bus.ready) begin
			seen.motor_number     = cmd_bus.motor_number;
			seen.position_command = cmd_bus.position_command;
			seen.velocity_command = cmd_bus.velocity_command;
			seen.torque_command   = cmd_bus.torque_command;
			seen.stiffness_gain   = cmd_bus.stiffness_gain;
			seen.damping_gain     = cmd_bus.damping_gain;
			seen.last_record      = cmd_bus.last_record;
			records_checked++;
			if (expected_records.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: record for motor %0d with nothing expected", $time,
						seen.motor_number);
			end else begin
				want = expected_records.pop_front();
				bad = (seen.motor_number !== want.motor_number) ||
					(seen.position_command !== want.position_command) ||
					(seen.velocity_command !== want.velocity_command) ||
					(seen.torque_command !== want.torque_command) ||
					(seen.stiffness_gain !== want.stiffness_gain) ||
					(seen.damping_gain !== want.damping_gain) ||
					(seen.last_record !== want.last_record);
				if (bad) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("%0t: expected motor %0d pos %0d vel %0d trq %0d kp %0d kd %0d last %0b",
							$time, want.motor_number, want.position_command,
							want.velocity_command, want.torque_command, want.stiffness_gain,
							want.damping_gain, want.last_record);
						$display("%0t:   actual motor %0d pos %0d vel %0d trq %0d kp %0d kd %0d last %0b",
							$time, seen.motor_number, seen.position_command,
							seen.velocity_command, seen.torque_command, seen.stiffness_gain,
							seen.damping_gain, seen.last_record);
					end
				end
			end
		end
	end

	// Watchdog: ends the run when no beat moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_bus.valid && tick_bus.ready) || (cmd_bus.valid && cmd_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: no beat for %0d cycles, %0d records still expected",
					QUIET_LIMIT, expected_records.size());
				$display("[sine_joint_setpoint_generator] ERROR");
				$finish;
			end
		end
	end

	// Sender side and test sequence.
	initial begin
		tick_bus.valid = 1'b0;
		tick_bus.period_tick = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_ACTIVE_MOTOR;
		cfg_bus.data = 32'd0;
		arst_n = 1'b0;
		sh_motor = RST_ACTIVE_MOTOR;
		sh_start = RST_START_DELAY;
		sh_run = RST_RUN_TICKS;
		sh_center = RST_CENTER;
		sh_amp = RST_AMPLITUDE;
		sh_step = RST_PHASE_STEP;
		sh_kp = RST_ACTIVE_KP;
		sh_kd = RST_ACTIVE_KD;
		tick_count_model = 32'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_motion_limits();
		test_motion_window();
		test_window_overflow();
		test_random_traffic();
		wait_for_drain();

		$display("Run covered %0d ticks, %0d empty beats and %0d register writes,",
			ticks_sent, empty_beats, writes_done);
		$display("with %0d command records checked and %0d mismatches.", records_checked,
			mismatches);
		if (mismatches == 0 && expected_records.size() == 0)
			$display("[sine_joint_setpoint_generator] OK");
		else
			$display("[sine_joint_setpoint_generator] ERROR");
		$finish;
	end

endmodule
